FILE: src/lors_pkg.sv
// shared types, constants and widths for the link overhead rate shaper
`default_nettype none

package lors_pkg;

  localparam int MAX_SEGS = 64;
  localparam int SEGS_W = $clog2(MAX_SEGS + 1);

  localparam int CMD_W = 2;
  localparam int TIME_W = 63;
  localparam int PLEN_W = 16;
  localparam int BYTE_W = 8;
  localparam int SEGCNT_W = 7;
  localparam int WIRE_W = 23;
  localparam int RATE_W = 34;
  localparam int SHIFT_W = 6;
  localparam int MINU_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 34;

  // compensation datapath widths
  localparam int LEN_W = PLEN_W + 1;
  localparam int FRAME_W = LEN_W;
  localparam int Q48_W = LEN_W - 4;
  localparam int RECIP_W = 16;
  localparam int RECIP_P_W = Q48_W + RECIP_W;
  localparam int RECIP_SHIFT = 17;
  localparam int CELLS_W = 11;
  localparam int PROD_W = PLEN_W + SEGS_W;
  localparam int TOT_W = FRAME_W + SEGS_W + 1;

  // rate multiply split into two partial products
  localparam int RATE_LO_W = 17;
  localparam int RATE_HI_W = RATE_W - RATE_LO_W;
  localparam int PP_W = WIRE_W + RATE_LO_W;
  localparam int DUR_W = WIRE_W + RATE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] ATM_ROUND = LEN_W'(47);
  localparam logic [FRAME_W-1:0] ATM_CELL_BYTES = FRAME_W'(53);
  localparam logic [LEN_W-1:0] PTM_ROUND = LEN_W'(63);
  localparam int PTM_SHIFT = 6;
  localparam int ATM_SHIFT16 = 4;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 16'hAAAB;

  localparam logic [WIRE_W-1:0] WIRE_MAX = {WIRE_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd2;

  localparam logic [1:0] LINK_ATM = 2'd1;
  localparam logic [1:0] LINK_PTM = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_MODE    = 3'd0,
    REG_STRIP_OFFSET = 3'd1,
    REG_OVERHEAD     = 3'd2,
    REG_MIN_UNIT     = 3'd3,
    REG_RATE         = 3'd4,
    REG_SHIFT        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              link_mode;
    logic                    strip_offset;
    logic signed [BYTE_W-1:0] overhead_bytes;
    logic [MINU_W-1:0]       min_unit;
    logic [RATE_W-1:0]       scaled_ns_per_byte;
    logic [SHIFT_W-1:0]      dur_shift;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TIME_W-1:0]   now_time;
    logic [PLEN_W-1:0]   packet_len;
    logic [BYTE_W-1:0]   net_offset;
    logic [PLEN_W-1:0]   seg_size;
    logic [BYTE_W-1:0]   header_len;
    logic [SEGCNT_W-1:0] seg_count;
    logic                queue_empty;
  } in_item_t;

  typedef struct packed {
    logic              eligible;
    logic              timer_arm;
    logic [WIRE_W-1:0] wire_len;
    logic [TIME_W-1:0] next_time;
  } out_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_time;
    logic              queue_empty;
    logic [WIRE_W-1:0] wire_len;
  } job_t;

endpackage

`default_nettype wire

FILE: src/link_overhead_rate_shaper_top.sv
// top level of the link overhead rate shaper with its configuration registers
//
// command channel in_valid / in_ready / in_data: check, idle arrival or send.
// result channel out_valid / out_ready / out_data: one result per command,
// in command order, with eligibility, timer request, wire length and the
// updated next send time.
// configuration: cfg_we writes cfg_wdata to register cfg_index;
// indexes past the last register are dropped. write only while idle.
// a front sequencer takes one command, runs the length compensation steps on
// a send and goes straight to the hand-off for other commands, then hands a
// job through a two-entry queue to the timing unit. the timing unit runs
// the rate multiply on a send with a nonzero rate (two partial products,
// shift, saturating add) and goes straight to its result otherwise. the
// front sequencer takes a new command only after it has handed on the job
// of the last one.
// reset clears the configuration registers and the next send time to zero and returns the sequencers to idle.
// a stalled receiver holds the result register; the queue and front
// sequencer keep taking work until the queue fills.

`default_nettype none

module link_overhead_rate_shaper_top
  import lors_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic push, q_full, q_pop, q_valid;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINK_MODE:    cfg_r.link_mode <= cfg_wdata[1:0];
        REG_STRIP_OFFSET: cfg_r.strip_offset <= cfg_wdata[0];
        REG_OVERHEAD:     cfg_r.overhead_bytes <= $signed(cfg_wdata[BYTE_W-1:0]);
        REG_MIN_UNIT:     cfg_r.min_unit <= cfg_wdata[MINU_W-1:0];
        REG_RATE:         cfg_r.scaled_ns_per_byte <= cfg_wdata[RATE_W-1:0];
        REG_SHIFT:        cfg_r.dur_shift <= cfg_wdata[SHIFT_W-1:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  lors_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  lors_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  lors_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/lors_front.sv
// front sequencer: accepts commands and works out the compensated wire length
`default_nettype none

module lors_front
  import lors_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_job,
  input  logic     q_full
);

  typedef enum logic [5:0] {
    FS_IDLE  = 6'b000001,
    FS_LAST  = 6'b000010,
    FS_PRE_B = 6'b000100,
    FS_CELL  = 6'b001000,
    FS_FRAME = 6'b010000,
    FS_PUSH  = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;
  in_item_t item_r;
  logic segd_r;
  logic [SEGS_W-1:0] factor_r;
  logic [PLEN_W-1:0] last_r;
  logic [LEN_W-1:0] pre_a_r, pre_b_r;
  logic [CELLS_W-1:0] cells_a_r, cells_b_r;
  logic [FRAME_W-1:0] frame_a_r, frame_b_r;

  logic segd;
  logic [SEGS_W-1:0] segs_c, nm1;
  logic [PROD_W-1:0] seg_prod;
  logic [PLEN_W-1:0] tail_len;
  logic [LEN_W-1:0] full_len;
  logic [TOT_W-1:0] total;
  logic [WIRE_W-1:0] wire_len;

  // offset strip, overhead and minimum unit, clamped at zero
  function automatic logic [LEN_W-1:0] comp_pre(input logic [LEN_W-1:0] len,
                                                input logic [BYTE_W-1:0] off,
                                                input cfg_t c);
    logic [LEN_W-1:0] l1;
    logic signed [LEN_W+1:0] s;
    logic [LEN_W-1:0] l2;
    if (!c.strip_offset) begin
      l1 = len;
    end else if (len > LEN_W'(off)) begin
      l1 = len - LEN_W'(off);
    end else begin
      l1 = '0;
    end
    s = $signed({2'b00, l1}) +
        $signed({{(LEN_W + 2 - BYTE_W){c.overhead_bytes[BYTE_W-1]}}, c.overhead_bytes});
    if (s[LEN_W+1]) begin
      l2 = '0;
    end else begin
      l2 = s[LEN_W-1:0];
    end
    if (l2 < LEN_W'(c.min_unit)) begin
      l2 = LEN_W'(c.min_unit);
    end
    return l2;
  endfunction

  // ceil(len / 48): divide by 16, then by 3 through a reciprocal
  function automatic logic [CELLS_W-1:0] atm_cells(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] x;
    logic [RECIP_P_W-1:0] p;
    x = len + ATM_ROUND;
    p = RECIP_P_W'(x[LEN_W-1:ATM_SHIFT16]) * RECIP_P_W'(DIV3_RECIP);
    return p[RECIP_SHIFT+CELLS_W-1:RECIP_SHIFT];
  endfunction

  function automatic logic [FRAME_W-1:0] framed(input logic [LEN_W-1:0] len,
                                                input logic [CELLS_W-1:0] cells,
                                                input logic [1:0] mode);
    logic [FRAME_W-1:0] f;
    unique case (mode)
      LINK_ATM: f = FRAME_W'(cells) * ATM_CELL_BYTES;
      LINK_PTM: f = len + ((len + PTM_ROUND) >> PTM_SHIFT);
      default:  f = len;
    endcase
    return f;
  endfunction

  assign in_ready = (state_r == FS_IDLE);

  always_comb begin
    segd = (item_r.seg_size != '0);
    if (item_r.seg_count == '0) begin
      segs_c = SEGS_W'(1);
    end else if (int'(item_r.seg_count) > MAX_SEGS) begin
      segs_c = SEGS_W'(MAX_SEGS);
    end else begin
      segs_c = SEGS_W'(item_r.seg_count);
    end
    nm1 = segs_c - SEGS_W'(1);
    seg_prod = PROD_W'(item_r.seg_size) * PROD_W'(nm1);
    if (PROD_W'(item_r.packet_len) > seg_prod) begin
      tail_len = item_r.packet_len - seg_prod[PLEN_W-1:0];
    end else begin
      tail_len = '0;
    end
    if (segd) begin
      full_len = LEN_W'(item_r.seg_size) + LEN_W'(item_r.header_len);
    end else begin
      full_len = LEN_W'(item_r.packet_len);
    end
  end

  always_comb begin
    total = TOT_W'(frame_a_r) * TOT_W'(factor_r) + (segd_r ? TOT_W'(frame_b_r) : '0);
    if (item_r.command != CMD_SEND) begin
      wire_len = '0;
    end else if (total > TOT_W'(WIRE_MAX)) begin
      wire_len = WIRE_MAX;
    end else begin
      wire_len = total[WIRE_W-1:0];
    end
  end

  assign push = (state_r == FS_PUSH) && !q_full;
  assign push_job = '{cmd: item_r.command, now_time: item_r.now_time,
                      queue_empty: item_r.queue_empty, wire_len: wire_len};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == CMD_SEND) ? FS_LAST : FS_PUSH;
        end
      end
      FS_LAST:  state_nxt = FS_PRE_B;
      FS_PRE_B: state_nxt = FS_CELL;
      FS_CELL:  state_nxt = FS_FRAME;
      FS_FRAME: state_nxt = FS_PUSH;
      FS_PUSH: begin
        if (!q_full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FS_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == FS_LAST) begin
      segd_r <= segd;
      factor_r <= segd ? nm1 : SEGS_W'(1);
      last_r <= tail_len;
      pre_a_r <= comp_pre(full_len, item_r.net_offset, cfg);
    end
    if (state_r == FS_PRE_B) begin
      pre_b_r <= comp_pre(LEN_W'(last_r), item_r.net_offset, cfg);
    end
    if (state_r == FS_CELL) begin
      cells_a_r <= atm_cells(pre_a_r);
      cells_b_r <= atm_cells(pre_b_r);
    end
    if (state_r == FS_FRAME) begin
      frame_a_r <= framed(pre_a_r, cells_a_r, cfg.link_mode);
      frame_b_r <= framed(pre_b_r, cells_b_r, cfg.link_mode);
    end
  end

endmodule

`default_nettype wire

FILE: src/lors_queue.sv
// two-entry job queue between the front sequencer and the timing unit
`default_nettype none

module lors_queue
  import lors_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic not_empty
);

  job_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0] count_r;
  logic do_push, do_pop;

  assign full = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: src/lors_back.sv
// timing unit: send time state, rate multiply and result register
`default_nettype none

module lors_back
  import lors_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    BS_IDLE   = 5'b00001,
    BS_MUL_LO = 5'b00010,
    BS_MUL_HI = 5'b00100,
    BS_SHIFT  = 5'b01000,
    BS_FIN    = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  job_t job_r;
  logic [PP_W-1:0] plo_r, phi_r;
  logic [DUR_W-1:0] dur_r;
  logic [TIME_W-1:0] nst_r;
  logic out_valid_r;
  out_item_t out_data_r;

  logic [DUR_W-1:0] prod;
  logic [TIME_W:0] sum;
  logic [TIME_W-1:0] sat_time;
  logic [TIME_W-1:0] nst_new;
  logic timer;
  logic finish;

  assign q_pop = (state_r == BS_IDLE) && q_valid;
  assign finish = (state_r == BS_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign prod = DUR_W'(plo_r) + {phi_r, {RATE_LO_W{1'b0}}};

  always_comb begin
    sum = {1'b0, nst_r} + (TIME_W + 1)'(dur_r);
    sat_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    nst_new = nst_r;
    timer = 1'b0;
    unique case (job_r.cmd)
      CMD_CHECK: timer = (nst_r > job_r.now_time);
      CMD_ARRIVE: begin
        if (job_r.queue_empty) begin
          if (nst_r > job_r.now_time) begin
            timer = 1'b1;
          end else begin
            nst_new = job_r.now_time;
          end
        end
      end
      CMD_SEND: begin
        nst_new = sat_time;
        timer = (sat_time > job_r.now_time) && !job_r.queue_empty;
      end
      default: timer = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          if (q_job.cmd == CMD_SEND && cfg.scaled_ns_per_byte != '0) begin
            state_nxt = BS_MUL_LO;
          end else begin
            state_nxt = BS_FIN;
          end
        end
      end
      BS_MUL_LO: state_nxt = BS_MUL_HI;
      BS_MUL_HI: state_nxt = BS_SHIFT;
      BS_SHIFT:  state_nxt = BS_FIN;
      BS_FIN: begin
        if (finish) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      nst_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        nst_r <= nst_new;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == BS_MUL_LO) begin
      plo_r <= PP_W'(job_r.wire_len) * PP_W'(cfg.scaled_ns_per_byte[RATE_LO_W-1:0]);
    end
    if (state_r == BS_MUL_HI) begin
      phi_r <= PP_W'(job_r.wire_len) * PP_W'(cfg.scaled_ns_per_byte[RATE_W-1:RATE_LO_W]);
    end
    if (q_pop) begin
      dur_r <= '0;
    end else if (state_r == BS_SHIFT) begin
      dur_r <= prod >> cfg.dur_shift;
    end
    if (finish) begin
      out_data_r <= '{eligible: (nst_new <= job_r.now_time), timer_arm: timer,
                      wire_len: job_r.wire_len, next_time: nst_new};
    end
  end

endmodule

`default_nettype wire

FILE: src/lors_checker.sv
// port-level assertions for the shaper top level and their bind
`default_nettype none

module lors_checker
  import lors_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic [3:0] pending_r;
  logic [TIME_W-1:0] last_time_r;
  logic in_xfer, out_xfer;

  assign in_xfer = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      last_time_r <= '0;
    end else begin
      if (in_xfer && !out_xfer) begin
        pending_r <= pending_r + 4'd1;
      end else if (out_xfer && !in_xfer) begin
        pending_r <= pending_r - 4'd1;
      end
      if (out_xfer) begin
        last_time_r <= out_data.next_time;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.eligible && out_data.timer_arm))
    else $error("timer requested while eligible");

  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.next_time >= last_time_r)
    else $error("next send time moved backward");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without an accepted command");

endmodule

bind link_overhead_rate_shaper_top lors_checker u_lors_checker (.*);

`default_nettype wire

FILE: dv/link_overhead_rate_shaper_checker.sv
// checker for the link overhead rate shaper: predicts each result and compares it on transfer
`timescale 1ns / 100ps

module link_overhead_rate_shaper_checker
  import lors_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    results_pending,
  output int                    results_checked
);

  logic [1:0]               link_mode;
  logic                     strip_offset;
  logic signed [BYTE_W-1:0] overhead_bytes;
  logic [MINU_W-1:0]        min_unit;
  logic [RATE_W-1:0]        ns_per_byte;
  logic [SHIFT_W-1:0]       dur_shift;
  logic [63:0]              send_time;
  out_item_t                results_due[$];
  int                       errors = 0;
  int                       checked = 0;

  function automatic longint wire_bytes(input longint len, input longint off);
    longint n;
    n = len;
    if (strip_offset) begin
      n = n - off;
    end
    if (n < 0) begin
      n = 0;
    end
    n = n + longint'(overhead_bytes);
    if (n < 0) begin
      n = 0;
    end
    if (n < longint'(min_unit)) begin
      n = longint'(min_unit);
    end
    case (link_mode)
      LINK_ATM: begin
        n = ((n + 47) / 48) * 53;
      end
      LINK_PTM: begin
        n = n + (n + 63) / 64;
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic out_item_t shape_step(input in_item_t it);
    out_item_t   r;
    logic [63:0] now;
    logic [63:0] dur;
    longint      wlen;
    longint      segs;
    longint      last;
    logic        timer;
    now = {1'b0, it.now_time};
    wlen = 0;
    timer = 1'b0;
    case (it.command)
      CMD_CHECK: begin
        timer = send_time > now;
      end
      CMD_ARRIVE: begin
        if (it.queue_empty) begin
          if (send_time > now) begin
            timer = 1'b1;
          end else begin
            send_time = now;
          end
        end
      end
      CMD_SEND: begin
        if (it.seg_size == '0) begin
          wlen = wire_bytes(longint'(it.packet_len), longint'(it.net_offset));
        end else begin
          segs = longint'(it.seg_count);
          if (segs == 0) begin
            segs = 1;
          end
          if (segs > MAX_SEGS) begin
            segs = MAX_SEGS;
          end
          last = longint'(it.packet_len) - longint'(it.seg_size) * (segs - 1);
          if (last < 0) begin
            last = 0;
          end
          wlen = wire_bytes(longint'(it.seg_size) + longint'(it.header_len),
                            longint'(it.net_offset)) * (segs - 1)
                 + wire_bytes(last, longint'(it.net_offset));
        end
        if (wlen > longint'(WIRE_MAX)) begin
          wlen = longint'(WIRE_MAX);
        end
        if (ns_per_byte != '0) begin
          dur = (64'(wlen) * 64'(ns_per_byte)) >> dur_shift;
          if (dur > 64'(TIME_MAX) - send_time) begin
            send_time = 64'(TIME_MAX);
          end else begin
            send_time = send_time + dur;
          end
        end
        timer = (send_time > now) && !it.queue_empty;
      end
      default: ;
    endcase
    r.eligible = send_time <= now;
    r.timer_arm = timer;
    r.wire_len = wlen[WIRE_W-1:0];
    r.next_time = send_time[TIME_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      link_mode = '0;
      strip_offset = 1'b0;
      overhead_bytes = '0;
      min_unit = '0;
      ns_per_byte = '0;
      dur_shift = '0;
      send_time = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINK_MODE:    link_mode = cfg_wdata[1:0];
          REG_STRIP_OFFSET: strip_offset = cfg_wdata[0];
          REG_OVERHEAD:     overhead_bytes = cfg_wdata[BYTE_W-1:0];
          REG_MIN_UNIT:     min_unit = cfg_wdata[MINU_W-1:0];
          REG_RATE:         ns_per_byte = cfg_wdata[RATE_W-1:0];
          REG_SHIFT:        dur_shift = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("result with nothing expected: %h", out_data);
          end
        end else begin
          want = results_due.pop_front();
          checked++;
          if (out_data.eligible !== want.eligible || out_data.timer_arm !== want.timer_arm
              || out_data.wire_len !== want.wire_len
              || out_data.next_time !== want.next_time) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on result %0d: eligible %0b/%0b timer_arm %0b/%0b",
                       checked, want.eligible, out_data.eligible,
                       want.timer_arm, out_data.timer_arm);
              $display("  wire_len %0d/%0d next_time %0d/%0d (expected/actual)",
                       want.wire_len, out_data.wire_len, want.next_time, out_data.next_time);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(shape_step(in_data));
      end
    end
    mismatches <= errors;
    results_pending <= results_due.size();
    results_checked <= checked;
  end

endmodule

FILE: dv/tb_link_overhead_rate_shaper_top.sv
// testbench top for the link overhead rate shaper: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_link_overhead_rate_shaper_top;
  import lors_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam logic [1:0] LINK_PLAIN = 2'd0;
  localparam logic [1:0] LINK_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_IDX = 3'd6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    fail_count;
  int                    results_pending;
  int                    results_checked;
  int                    tx_idle_pct = 25;
  int                    rx_idle_pct = 78;
  int                    rx_hold_left = 0;
  int                    quiet_cycles = 0;
  int                    settings_done = 0;
  int                    cmd_count[4] = '{0, 0, 0, 0};
  longint unsigned       step_ns = 1000;
  logic [TIME_W-1:0]     seen_next = '0;

  link_overhead_rate_shaper_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  link_overhead_rate_shaper_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (fail_count),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen_next <= out_data.next_time;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("link_overhead_rate_shaper_top test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [1:0] mode, input logic strip,
                                input logic [BYTE_W-1:0] ovh, input logic [MINU_W-1:0] minu,
                                input logic [RATE_W-1:0] rate, input logic [SHIFT_W-1:0] shift);
    longint unsigned len_est;
    write_reg(REG_LINK_MODE, CFG_DATA_W'(mode));
    write_reg(REG_STRIP_OFFSET, CFG_DATA_W'(strip));
    write_reg(REG_OVERHEAD, CFG_DATA_W'(ovh));
    write_reg(REG_MIN_UNIT, CFG_DATA_W'(minu));
    write_reg(REG_RATE, CFG_DATA_W'(rate));
    write_reg(REG_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_SPARE_IDX, CFG_DATA_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    len_est = (minu > 800) ? minu : 800;
    step_ns = (rate == '0) ? 1000 : ((len_est * rate) >> shift) + 1;
    settings_done++;
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    cmd_count[it.command]++;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, tx_idle_pct / 6 + 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                                        input int plen, input int off, input int seg,
                                        input int hlen, input int segs, input logic empty);
    in_item_t it;
    it.command = cmd;
    it.now_time = now;
    it.packet_len = PLEN_W'(plen);
    it.net_offset = BYTE_W'(off);
    it.seg_size = PLEN_W'(seg);
    it.header_len = BYTE_W'(hlen);
    it.seg_count = SEGCNT_W'(segs);
    it.queue_empty = empty;
    return it;
  endfunction

  // times mostly straddle the last reported send time so both eligibility outcomes occur
  function automatic logic [TIME_W-1:0] pick_now();
    logic [63:0] span;
    logic [63:0] off;
    logic [63:0] t;
    int          roll;
    span = 2 * step_ns + 1;
    off = {$urandom, $urandom} % span;
    roll = $urandom_range(99);
    if (roll < 4) begin
      t = {$urandom, $urandom} >> 1;
    end else if (roll < 52) begin
      t = 64'(seen_next) + off;
    end else if (64'(seen_next) > off) begin
      t = 64'(seen_next) - off;
    end else begin
      t = '0;
    end
    if (t > 64'(TIME_MAX)) begin
      t = 64'(TIME_MAX);
    end
    return t[TIME_W-1:0];
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int       roll;
    int       segs;
    roll = $urandom_range(99);
    if (roll < 25) begin
      it.command = CMD_CHECK;
    end else if (roll < 45) begin
      it.command = CMD_ARRIVE;
    end else if (roll < 95) begin
      it.command = CMD_SEND;
    end else begin
      it.command = CMD_IGNORED;
    end
    it.now_time = pick_now();
    it.packet_len = PLEN_W'($urandom);
    it.net_offset = BYTE_W'($urandom);
    it.seg_size = PLEN_W'($urandom);
    it.header_len = BYTE_W'($urandom);
    it.seg_count = SEGCNT_W'($urandom);
    it.queue_empty = 1'($urandom);
    if (it.command == CMD_SEND) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        it.seg_size = '0;
        it.packet_len = PLEN_W'($urandom_range(40, 1600));
        it.net_offset = BYTE_W'($urandom_range(0, 60));
      end else if (roll < 80) begin
        segs = $urandom_range(1, 8);
        it.seg_size = PLEN_W'($urandom_range(64, 1500));
        it.seg_count = SEGCNT_W'(segs);
        it.header_len = BYTE_W'($urandom_range(20, 80));
        it.packet_len = PLEN_W'(it.seg_size * segs - $urandom_range(0, it.seg_size - 1));
      end else if (roll < 88) begin
        it.seg_size = '0;
      end
    end
    return it;
  endfunction

  task automatic run_random(input int count, input int pause_at, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        wait_drained();
      end
      if (i == hold_at) begin
        rx_hold_left = HOLD_CYCLES;
      end
      send_item(make_item());
    end
    wait_drained();
  endtask

  initial begin
    int sh;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_settings(LINK_ATM, 1'b1, 8'h80, 16'd0, RATE_W'((5 << 8) | 63), 6'd8);
    send_item(make_cmd(CMD_CHECK, 63'd0, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_ARRIVE, 63'd1000, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_CHECK, 63'd999, 0, 0, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_ARRIVE, 63'd500, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_ARRIVE, 63'd2000, 0, 0, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_IGNORED, 63'd2000, 1500, 20, 0, 40, 1, 1'b1));
    send_item(make_cmd(CMD_SEND, 63'd2000, 0, 255, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_SEND, 63'd2000, 65535, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_SEND, 63'd3000, 200, 20, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_SEND, 63'd4000, 1500, 14, 1000, 40, 0, 1'b0));
    send_item(make_cmd(CMD_SEND, 63'd4000, 65535, 255, 100, 255, 127, 1'b1));
    send_item(make_cmd(CMD_SEND, 63'd5000, 10, 20, 1000, 40, 5, 1'b0));
    send_item(make_cmd(CMD_SEND, 63'd5000, 65535, 0, 65535, 255, 64, 1'b0));
    send_item(make_cmd(CMD_CHECK, TIME_MAX, 0, 0, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_ARRIVE, TIME_MAX, 0, 0, 0, 0, 1, 1'b0));
    wait_drained();
    apply_settings(LINK_PTM, 1'b0, 8'h7F, 16'hFFFF, RATE_W'(1), 6'd0);
    send_item(make_cmd(CMD_SEND, 63'd0, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_SEND, 63'd0, 4096, 0, 64, 0, 64, 1'b0));
    send_item(make_cmd(CMD_CHECK, 63'd0, 0, 0, 0, 0, 1, 1'b0));
    wait_drained();

    apply_settings(LINK_PLAIN, 1'b0, 8'h00, 16'd0, RATE_W'(0), 6'd0);
    run_random(210, -1, -1);

    tx_idle_pct = 78;
    rx_idle_pct = 25;
    sh = $urandom_range(0, 24);
    apply_settings(LINK_ATM, 1'b1, 8'h7F, MINU_W'($urandom_range(0, 200)),
                   RATE_W'((longint'($urandom_range(1, 8)) << sh) | $urandom_range(0, 255)),
                   SHIFT_W'(sh));
    run_random(210, 100, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(LINK_PTM, 1'($urandom), 8'h80, 16'd0, RATE_W'($urandom_range(1, 1000)),
                   6'd0);
    run_random(210, -1, 50);

    apply_settings(LINK_SPARE, 1'b1, BYTE_W'($urandom), MINU_W'($urandom_range(0, 2000)),
                   RATE_W'({$urandom, $urandom}), 6'd63);
    run_random(210, -1, -1);

    apply_settings(LINK_PTM, 1'b1, 8'h7F, 16'hFFFF, {RATE_W{1'b1}}, 6'd34);
    run_random(190, -1, -1);

    // push the send time into saturation
    apply_settings(LINK_PTM, 1'b1, 8'h7F, 16'hFFFF, {RATE_W{1'b1}}, 6'd0);
    send_item(make_cmd(CMD_ARRIVE, TIME_MAX - 63'd5, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_SEND, TIME_MAX - 63'd5, 65535, 40, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_CHECK, TIME_MAX - 63'd1, 0, 0, 0, 0, 1, 1'b0));
    send_item(make_cmd(CMD_ARRIVE, TIME_MAX, 0, 0, 0, 0, 1, 1'b1));
    send_item(make_cmd(CMD_CHECK, TIME_MAX, 0, 0, 0, 0, 1, 1'b1));
    wait_drained();

    $display("covered %0d transfers: %0d check, %0d idle arrival, %0d send, %0d unused command",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[CMD_CHECK], cmd_count[CMD_ARRIVE], cmd_count[CMD_SEND],
             cmd_count[CMD_IGNORED]);
    $display("%0d results compared over %0d register settings, with receiver hold-off and drains",
             results_checked, settings_done);
    if (fail_count == 0 && results_pending == 0) begin
      $display("link_overhead_rate_shaper_top test passed");
    end else begin
      $display("link_overhead_rate_shaper_top test failed");
    end
    $finish;
  end

endmodule
